### src/tka_pkg.sv
// package for the typed key argsort block
// types, constants and the key mapping function; no dependencies
package tka_pkg;

  localparam int MaxItems = 64;
  localparam int IdxW = $clog2(MaxItems);
  localparam int CntW = $clog2(MaxItems + 1);
  localparam int KeyW = 64;

  typedef enum logic [2:0] {
    TYPE_INT32   = 3'd0,
    TYPE_UINT32  = 3'd1,
    TYPE_INT64   = 3'd2,
    TYPE_UINT64  = 3'd3,
    TYPE_FLOAT32 = 3'd4,
    TYPE_FLOAT64 = 3'd5
  } elem_type_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SCAN,
    ST_EMIT
  } state_t;

  // one entry of the queue between front and back
  typedef struct packed {
    logic [KeyW-1:0] key;
    logic            last;
  } key_word_t;

  localparam logic [31:0] Sign32  = 32'h8000_0000;
  localparam logic [63:0] Sign64  = 64'h8000_0000_0000_0000;
  localparam logic [63:0] AllOnes = 64'hFFFF_FFFF_FFFF_FFFF;

  // map a raw bit pattern to an unsigned sortable key
  function automatic logic [63:0] make_key(input logic [63:0] raw, input logic [2:0] typ);
    logic [31:0] lo;
    logic [63:0] k;
    lo = raw[31:0];
    case (typ)
      TYPE_INT32:  k = {32'd0, lo ^ Sign32};
      TYPE_UINT32: k = {32'd0, lo};
      TYPE_INT64:  k = raw ^ Sign64;
      TYPE_FLOAT32: begin
        if (lo[30:23] == 8'hFF && lo[22:0] != 23'd0) k = AllOnes;
        else if (lo[31]) k = {32'd0, ~lo};
        else k = {32'd0, lo | Sign32};
      end
      TYPE_FLOAT64: begin
        if (raw[62:52] == 11'h7FF && raw[51:0] != 52'd0) k = AllOnes;
        else if (raw[63]) k = ~raw;
        else k = raw | Sign64;
      end
      default: k = raw;
    endcase
    return k;
  endfunction

endpackage

### src/typed_key_argsort.sv
// top level of the typed key argsort block
// instantiates tka_front and tka_back; depends on tka_pkg
//
// channel   dir  payload
// s_axis    in   tdata[63:0] raw_value, tlast is_last
// m_axis    out  tdata[5:0] sorted_index, tlast last_index
// cfg       in   cfg_wdata[2:0] element_type
//
// loading: each element is inserted by one compare-and-shift step per cycle,
// from the end down to its key's position, on a one-read one-write key memory.
// emitting: each index goes through a registered memory read, then the output.
// reset clears counters and the queue; store contents are left undefined.
// input stalls only while the two-word queue is full (it is popped on load).
module typed_key_argsort (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // raw_value
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // sorted_index [5:0], zeros above
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_wdata
);
  import tka_pkg::*;

  logic [2:0] elem_type;
  key_word_t  q_word;
  logic       q_valid;
  logic       q_pop;
  logic       busy;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) elem_type <= TYPE_INT32;
    else if (cfg_we) elem_type <= cfg_wdata;
  end

  tka_front u_front (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tlast,
    .elem_type, .q_word, .q_valid, .q_pop
  );

  tka_back u_back (
    .clk, .rst, .q_word, .q_valid, .q_pop,
    .m_tvalid, .m_tready, .m_tdata, .m_tlast, .busy
  );

  // pop only from a nonempty queue
  a_pop_valid: assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("pop from empty queue");

  // a held output word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output word changed while stalled");

  // no new pop while the back end is working
  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst) busy |-> !q_pop)
    else $error("pop while busy");

endmodule

### src/tka_front.sv
// front end: accepts words, maps them to keys, pushes into a two-entry queue
// depends on tka_pkg
module tka_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [63:0]         s_tdata,
  input  logic                s_tlast,
  input  logic [2:0]          elem_type,
  output tka_pkg::key_word_t  q_word,
  output logic                q_valid,
  input  logic                q_pop
);
  import tka_pkg::*;

  key_word_t   slot [2];
  logic        wr_ptr, rd_ptr;
  logic [1:0]  fill;
  logic        push;

  assign s_tready = (fill != 2'd2);
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (fill != 2'd0);
  assign q_word   = slot[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= '{key: make_key(s_tdata, elem_type), last: s_tlast};
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

### src/tka_back.sv
// back end: sorted store in memory, one compare-and-shift step per cycle,
// then emits indices in order; depends on tka_pkg
module tka_back (
  input  logic                   clk,
  input  logic                   rst,
  input  tka_pkg::key_word_t     q_word,
  input  logic                   q_valid,
  output logic                   q_pop,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [7:0]             m_tdata,
  output logic                   m_tlast,
  output logic                   busy
);
  import tka_pkg::*;

  logic [KeyW-1:0] key_mem [MaxItems];
  logic [IdxW-1:0] idx_mem [MaxItems];

  state_t          state, state_next;
  logic [CntW-1:0] count;
  logic [CntW-1:0] pos;
  logic [KeyW-1:0] new_key;
  logic            new_last;
  logic [KeyW-1:0] rd_key;
  logic [IdxW-1:0] rd_idx;
  logic            rd_ok;
  logic [CntW-1:0] emit_ptr;
  logic            out_valid;
  logic [IdxW-1:0] out_idx;
  logic            out_last;
  logic            done_scan;
  logic            shift;
  logic            batch_end;
  logic            out_free;
  logic [CntW-1:0] rd_addr;

  // scan: rd_key holds entry pos-1 once rd_ok
  assign done_scan = rd_ok && (pos == '0 || rd_key <= new_key);
  assign shift     = rd_ok && pos != '0 && rd_key > new_key;
  assign batch_end = new_last || (count + 1'b1 == CntW'(MaxItems));
  assign out_free  = !out_valid || m_tready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD: if (q_valid) state_next = ST_SCAN;
      ST_SCAN: if (done_scan) state_next = batch_end ? ST_EMIT : ST_LOAD;
      ST_EMIT: if (rd_ok && out_free && emit_ptr + 1'b1 == count) state_next = ST_LOAD;
      default: state_next = ST_LOAD;
    endcase
  end

  // outputs
  always_comb begin
    q_pop = (state == ST_LOAD) && q_valid;
    busy  = (state != ST_LOAD);
  end

  // read address for the memory
  always_comb begin
    if (state == ST_EMIT) rd_addr = emit_ptr;
    else if (state == ST_SCAN && shift) rd_addr = pos - CntW'(2);
    else rd_addr = (q_pop ? count : pos) - 1'b1;
  end

  // memory read port
  always_ff @(posedge clk) begin
    rd_key <= key_mem[rd_addr[IdxW-1:0]];
    rd_idx <= idx_mem[rd_addr[IdxW-1:0]];
  end

  // memory write port
  always_ff @(posedge clk) begin
    if (state == ST_SCAN && rd_ok) begin
      if (shift) begin
        key_mem[pos[IdxW-1:0]] <= rd_key;
        idx_mem[pos[IdxW-1:0]] <= rd_idx;
      end else begin
        key_mem[pos[IdxW-1:0]] <= new_key;
        idx_mem[pos[IdxW-1:0]] <= count[IdxW-1:0];
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      count     <= '0;
      pos       <= '0;
      rd_ok     <= 1'b0;
      emit_ptr  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && m_tready) out_valid <= 1'b0;
      case (state)
        ST_LOAD: begin
          rd_ok <= 1'b0;
          if (q_valid) begin
            pos   <= count;
            rd_ok <= 1'b1;
          end
        end
        ST_SCAN: begin
          if (shift) pos <= pos - 1'b1;
          if (done_scan) begin
            rd_ok <= 1'b0;
            if (batch_end) begin
              count    <= count + 1'b1;
              emit_ptr <= '0;
            end else begin
              count <= count + 1'b1;
            end
          end
        end
        ST_EMIT: begin
          // rd_ok marks that rd_idx holds entry emit_ptr
          if (!rd_ok) begin
            rd_ok <= 1'b1;
          end else if (out_free) begin
            out_valid <= 1'b1;
            emit_ptr  <= emit_ptr + 1'b1;
            rd_ok     <= 1'b0;
            if (emit_ptr + 1'b1 == count) count <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (state == ST_EMIT && rd_ok && out_free) begin
      out_idx  <= rd_idx;
      out_last <= (emit_ptr + 1'b1 == count);
    end
  end

  // latch the key under insertion
  always_ff @(posedge clk) begin
    if (q_pop) begin
      new_key  <= q_word.key;
      new_last <= q_word.last;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(8-IdxW){1'b0}}, out_idx};
  assign m_tlast  = out_last;

endmodule
